// ----- design/one_wire_bus_master_top_assert.svh -----
// ----------------------------------------------------------------------------
// One-wire bus master assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_TOP_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_TOP_ASSERT_SVH

// same-cycle implication, cleared during reset
`define OWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, cleared during reset
`define OWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/owm_pkg.sv -----
// ----------------------------------------------------------------------------
// One-wire bus master package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int TICK_COUNT_WIDTH = 10;
    localparam int TICK_REACH       = 1 << TICK_COUNT_WIDTH;
    localparam int LIM_W            = TICK_COUNT_WIDTH + 1;
    localparam int CMP_W            = 17;
    localparam int CFG_W            = 10;
    localparam int CFG_IDX_W        = 2;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [CFG_W-1:0] RESET_LOW_DEFAULT    = 10'd500;
    localparam logic [CFG_W-1:0] PRESENCE_SMP_DEFAULT = 10'd100;
    localparam logic [CFG_W-1:0] PRESENCE_TAIL_DEFAULT = 10'd400;
    localparam logic [CFG_W-1:0] SLOT_DEFAULT         = 10'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_SMP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_TAIL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT          = 2'd3;

    localparam logic [1:0] FUNC_RESET = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_RLOW  = 5'b00010,
        PH_RREL  = 5'b00100,
        PH_RTAIL = 5'b01000,
        PH_SLOT  = 5'b10000
    } phase_t;

    // one tick request, as carried on the input channel
    typedef struct packed {
        logic       line_level;
        logic [7:0] cmd_data;
        logic [1:0] func;
        logic       cmd_valid;
    } cmd_t;

    // one tick result, packed lowest field in the lowest bits
    typedef struct packed {
        logic [3:0] pad;
        logic [7:0] crc;
        logic [7:0] read_data;
        logic       presence;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } res_t;

    function automatic logic [LIM_W-1:0] clamp_ticks(logic [CFG_W-1:0] v,
                                                     logic [CFG_W-1:0] lo);
        logic [CMP_W-1:0] vx;
        vx = CMP_W'(v);
        if (v < lo) begin
            return LIM_W'(lo);
        end
        if (vx > CMP_W'(TICK_REACH)) begin
            return LIM_W'(TICK_REACH);
        end
        return LIM_W'(v);
    endfunction

    function automatic logic [7:0] crc_fold(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- design/owm_in_stage.sv -----
// ----------------------------------------------------------------------------
// One-wire bus master input register
// Holds one tick request until the bus controller consumes it.
// ----------------------------------------------------------------------------
module owm_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,   // [0] cmd_valid, [8:1] cmd_data, [9] line_level
    input  logic [1:0]    s_tuser,   // [1:0] func
    input  logic          advance,
    output logic          item_valid,
    output owm_pkg::cmd_t item
);
    import owm_pkg::*;

    logic valid_reg;
    cmd_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd_valid  <= s_tdata[0];
            item_reg.cmd_data   <= s_tdata[8:1];
            item_reg.line_level <= s_tdata[9];
            item_reg.func       <= s_tuser;
        end
    end

endmodule

// ----- design/owm_ctrl.sv -----
// ----------------------------------------------------------------------------
// One-wire bus master controller
// Timing registers, bus phase sequencer, shift byte and CRC-8 accumulator.
// ----------------------------------------------------------------------------
module owm_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [owm_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            advance,
    input  owm_pkg::cmd_t                   item,
    output owm_pkg::res_t                   res
);
    import owm_pkg::*;

    localparam int TCW = TICK_COUNT_WIDTH;

    logic [CFG_W-1:0] low_cfg_reg, smp_cfg_reg, tail_cfg_reg, slot_cfg_reg;

    phase_t         phase_reg, phase_next;
    logic [TCW-1:0] tick_reg, tick_next;
    logic [2:0]     bit_reg, bit_next;
    logic [7:0]     shift_reg, shift_next;
    logic           present_reg, present_next;
    logic [7:0]     crc_reg, crc_next;
    logic [1:0]     kind_reg, kind_next;
    logic [7:0]     last_read_reg, last_read_next;

    logic [LIM_W-1:0] low_n, smp_n, tail_n, slot_n, limit, tick_inc;
    logic             last, reading, drive, busy, done;
    phase_t           ph;

    assign low_n  = clamp_ticks(low_cfg_reg, 10'd1);
    assign smp_n  = clamp_ticks(smp_cfg_reg, 10'd1);
    assign tail_n = clamp_ticks(tail_cfg_reg, 10'd0);
    assign slot_n = clamp_ticks(slot_cfg_reg, 10'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_cfg_reg  <= RESET_LOW_DEFAULT;
            smp_cfg_reg  <= PRESENCE_SMP_DEFAULT;
            tail_cfg_reg <= PRESENCE_TAIL_DEFAULT;
            slot_cfg_reg <= SLOT_DEFAULT;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RESET_LOW:     low_cfg_reg  <= cfg_data;
                CFG_PRESENCE_SMP:  smp_cfg_reg  <= cfg_data;
                CFG_PRESENCE_TAIL: tail_cfg_reg <= cfg_data;
                CFG_SLOT:          slot_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ph             = phase_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        present_next   = present_reg;
        crc_next       = crc_reg;
        kind_next      = kind_reg;
        last_read_next = last_read_reg;
        drive          = 1'b0;
        busy           = 1'b0;
        done           = 1'b0;
        reading        = 1'b0;

        // take a new command only while idle; func 3 is dropped
        if (phase_reg == PH_IDLE && item.cmd_valid && item.func inside {FUNC_RESET,
                FUNC_WRITE, FUNC_READ}) begin
            kind_next = item.func;
            tick_next = '0;
            bit_next  = '0;
            if (item.func == FUNC_RESET) begin
                ph       = PH_RLOW;
                crc_next = '0;
            end else begin
                ph         = PH_SLOT;
                shift_next = (item.func == FUNC_WRITE) ? item.cmd_data : 8'h00;
            end
        end

        case (ph)
            PH_RLOW:  limit = low_n;
            PH_RREL:  limit = smp_n;
            PH_RTAIL: limit = tail_n;
            default:  limit = slot_n;
        endcase
        tick_inc = LIM_W'(tick_next) + LIM_W'(1);
        last     = (tick_inc >= limit);
        phase_next = ph;

        case (ph)
            PH_RLOW: begin
                busy  = 1'b1;
                drive = 1'b1;
                if (last) begin
                    phase_next = PH_RREL;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_inc[TCW-1:0];
                end
            end
            PH_RREL: begin
                busy = 1'b1;
                if (last) begin
                    present_next = !item.line_level;
                    tick_next    = '0;
                    if (!item.line_level && tail_n != '0) begin
                        phase_next = PH_RTAIL;
                    end else begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end else begin
                    tick_next = tick_inc[TCW-1:0];
                end
            end
            PH_RTAIL: begin
                busy = 1'b1;
                if (last) begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    done       = 1'b1;
                end else begin
                    tick_next = tick_inc[TCW-1:0];
                end
            end
            PH_SLOT: begin
                busy    = 1'b1;
                reading = (kind_next == FUNC_READ);
                if (tick_next == '0) begin
                    drive = 1'b1;
                end else if (!reading) begin
                    // hold low through the middle ticks for a 0 bit
                    drive = (tick_inc < slot_n) && !shift_next[bit_next];
                end else if (tick_next == TCW'(1)) begin
                    shift_next = {item.line_level, shift_next[7:1]};
                end
                if (last) begin
                    tick_next = '0;
                    if (bit_next == 3'd7) begin
                        if (reading) begin
                            last_read_next = shift_next;
                            crc_next       = crc_fold(crc_next, shift_next);
                        end
                        bit_next   = '0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end else begin
                        bit_next = bit_next + 3'd1;
                    end
                end else begin
                    tick_next = tick_inc[TCW-1:0];
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        res.pad       = '0;
        res.drive_low = drive;
        res.busy_res  = busy;
        res.done_res  = done;
        res.presence  = present_next;
        res.read_data = last_read_next;
        res.crc       = crc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            present_reg   <= 1'b0;
            crc_reg       <= '0;
            kind_reg      <= '0;
            last_read_reg <= '0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            present_reg   <= present_next;
            crc_reg       <= crc_next;
            kind_reg      <= kind_next;
            last_read_reg <= last_read_next;
        end
    end

endmodule

// ----- design/owm_out_stage.sv -----
// ----------------------------------------------------------------------------
// One-wire bus master result register
// Holds one tick result until the receiver takes it.
// ----------------------------------------------------------------------------
module owm_out_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  owm_pkg::res_t res,
    output logic          free,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata   // [0] drive_low, [1] busy_res, [2] done_res,
                                    // [3] presence, [11:4] read_data, [19:12] crc
);
    import owm_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// ----- design/one_wire_bus_master_top.sv -----
// ----------------------------------------------------------------------------
// One-wire bus master top level
// Tick-driven single-wire bus master with presence detect and CRC-8.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is one bus tick (nominally 1 us): it carries
//   an optional command (func in s_tuser) and the sampled line level. Every
//   request yields exactly one result on the m_ channel with the drive_low
//   level for that tick, busy/done flags, the last presence answer, the last
//   read byte and the running CRC-8.
//   A request passes an input register, then the sequencer logic feeding the
//   result register. Throughput is one tick per cycle while m_tready stays
//   high. Timing registers are written through cfg_we/cfg_index/cfg_data
//   when idle; the user must keep to this, the block does not enforce it.
//   Reset (aresetn low, synchronous) empties both registers, returns the
//   sequencer to idle, clears presence, read byte and CRC, and loads the
//   default timings (500/100/400/50 ticks).
//   When m_tready is low the result is held; one more request is taken into
//   the input register, after which s_tready drops until the result moves.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [0] cmd_valid, [8:1] cmd_data,
                                                     // [9] line_level
    input  logic [1:0]                    s_tuser,   // [1:0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [0] drive_low, [1] busy_res,
                                                     // [2] done_res, [3] presence,
                                                     // [11:4] read_data, [19:12] crc
    input  logic                          cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [owm_pkg::CFG_W-1:0]     cfg_data
);
    import owm_pkg::*;

    cmd_t item;
    res_t res;
    logic item_valid, out_free, advance;

    assign advance = item_valid && out_free;

    owm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    owm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .res       (res)
    );

    owm_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`include "one_wire_bus_master_top_assert.svh"

    `OWM_ASSERT_NOW(a_done_busy, m_tvalid && m_tdata[2], m_tdata[1],
        "done without busy")
    `OWM_ASSERT_NOW(a_drive_busy, m_tvalid && m_tdata[0], m_tdata[1],
        "line driven while not busy")
    `OWM_ASSERT_NOW(a_full_stall, item_valid && m_tvalid && !m_tready, !s_tready,
        "request taken with both stages full")
    `OWM_ASSERT_NEXT(a_advance_out, advance, m_tvalid,
        "advanced tick produced no result")

endmodule

// ----- dv/one_wire_bus_master_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// One-wire bus master testbench
// Sends bus ticks, with and without commands, through the request channel.
// Every result is checked against a tick-accurate model of the sequencer,
// run under short timing settings, including the smallest and below-minimum
// values, with random gaps on the sender side and stalls on the receiver.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top_tb;
    import owm_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_TICKS  = 420;
    localparam int RANDOM_PHASES = 7;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int LINE_LOW  = 0;
    localparam int LINE_HIGH = 1;
    localparam int LINE_RAND = 2;

    // one directed command, with its final presence/read/crc where known
    typedef struct {
        logic       vld;
        logic [1:0] func;
        logic [7:0] data;
        int         line_mode;
        bit         chk;
        logic       pres;
        logic [7:0] rd;
        logic [7:0] crcv;
    } cmd_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [15:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = FUNC_RESET;
    logic                 m_tready  = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RESET_LOW;
    logic [CFG_W-1:0]     cfg_data  = '0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [23:0]          m_tdata;

    // timing registers as the block should hold them
    logic [CFG_W-1:0] t_low  = RESET_LOW_DEFAULT;
    logic [CFG_W-1:0] t_smp  = PRESENCE_SMP_DEFAULT;
    logic [CFG_W-1:0] t_tail = PRESENCE_TAIL_DEFAULT;
    logic [CFG_W-1:0] t_slot = SLOT_DEFAULT;

    // sequencer state
    phase_t     bus_ph    = PH_IDLE;
    int         tick_cnt  = 0;
    int         bit_idx   = 0;
    logic [7:0] shift_reg = '0;
    logic       present   = 1'b0;
    logic [7:0] crc_acc   = '0;
    logic [7:0] last_byte = '0;
    logic [1:0] kind      = FUNC_RESET;

    res_t     tick_q[$];
    int       errors  = 0;
    int       snd_pct = 0;
    int       rcv_pct = 0;
    int       quiet   = 0;
    cmd_row_t plan[11];

    one_wire_bus_master_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    function automatic int span(logic [CFG_W-1:0] v, int lo);
        int x;
        x = int'(v);
        if (x < lo) begin
            return lo;
        end
        if (x > TICK_REACH) begin
            return TICK_REACH;
        end
        return x;
    endfunction

    function automatic logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = {1'b0, c[7:1]} ^ (c[0] ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic logic line_of(int mode);
        if (mode == LINE_LOW) begin
            return 1'b0;
        end
        if (mode == LINE_HIGH) begin
            return 1'b1;
        end
        return 1'($urandom_range(1));
    endfunction

    function automatic cmd_t rand_cmd(bit want);
        cmd_t c;
        int   sel;
        sel = $urandom_range(9);
        c.cmd_valid  = want;
        c.func       = (sel < 3) ? FUNC_RESET : (sel < 6) ? FUNC_WRITE :
                       (sel < 9) ? FUNC_READ : FUNC_UNUSED;
        c.cmd_data   = 8'($urandom_range(255));
        c.line_level = 1'($urandom_range(1));
        return c;
    endfunction

    // advance the sequencer by one tick and form that tick's result
    task automatic bus_tick(input cmd_t c, output res_t r);
        int   low_n, smp_n, tail_n, slot_n, lim;
        logic fin, rd_mode, bitv;
        low_n  = span(t_low, 1);
        smp_n  = span(t_smp, 1);
        tail_n = span(t_tail, 0);
        slot_n = span(t_slot, 2);
        r = '0;
        if (bus_ph == PH_IDLE && c.cmd_valid && c.func != FUNC_UNUSED) begin
            kind     = c.func;
            tick_cnt = 0;
            bit_idx  = 0;
            if (c.func == FUNC_RESET) begin
                bus_ph  = PH_RLOW;
                crc_acc = '0;
            end else begin
                bus_ph    = PH_SLOT;
                shift_reg = (c.func == FUNC_WRITE) ? c.cmd_data : 8'h00;
            end
        end
        if (bus_ph != PH_IDLE) begin
            r.busy_res = 1'b1;
            case (bus_ph)
                PH_RLOW:  lim = low_n;
                PH_RREL:  lim = smp_n;
                PH_RTAIL: lim = tail_n;
                default:  lim = slot_n;
            endcase
            fin = (tick_cnt + 1 >= lim);
            case (bus_ph)
                PH_RLOW: begin
                    r.drive_low = 1'b1;
                    if (fin) begin
                        bus_ph   = PH_RREL;
                        tick_cnt = 0;
                    end else begin
                        tick_cnt++;
                    end
                end
                PH_RREL: begin
                    if (fin) begin
                        present  = ~c.line_level;
                        tick_cnt = 0;
                        if (present && tail_n > 0) begin
                            bus_ph = PH_RTAIL;
                        end else begin
                            bus_ph     = PH_IDLE;
                            r.done_res = 1'b1;
                        end
                    end else begin
                        tick_cnt++;
                    end
                end
                PH_RTAIL: begin
                    if (fin) begin
                        bus_ph     = PH_IDLE;
                        tick_cnt   = 0;
                        r.done_res = 1'b1;
                    end else begin
                        tick_cnt++;
                    end
                end
                default: begin
                    rd_mode = (kind == FUNC_READ);
                    if (tick_cnt == 0) begin
                        r.drive_low = 1'b1;
                    end else if (!rd_mode) begin
                        // a zero bit keeps the line low up to the recovery tick
                        bitv = shift_reg[bit_idx];
                        r.drive_low = (tick_cnt + 1 < slot_n) && !bitv;
                    end else if (tick_cnt == 1) begin
                        shift_reg = {c.line_level, shift_reg[7:1]};
                    end
                    if (fin) begin
                        tick_cnt = 0;
                        if (bit_idx >= 7) begin
                            if (rd_mode) begin
                                last_byte = shift_reg;
                                crc_acc   = crc8_step(crc_acc, shift_reg);
                            end
                            bit_idx    = 0;
                            bus_ph     = PH_IDLE;
                            r.done_res = 1'b1;
                        end else begin
                            bit_idx++;
                        end
                    end else begin
                        tick_cnt++;
                    end
                end
            endcase
        end
        r.presence  = present;
        r.read_data = last_byte;
        r.crc       = crc_acc;
    endtask

    task automatic send_tick(input cmd_t c, input bit use_row, input cmd_row_t row,
                             output res_t r);
        while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, c.line_level, c.cmd_data, c.cmd_valid};
        s_tuser  <= c.func;
        do @(posedge aclk); while (!s_tready);
        bus_tick(c, r);
        // on the last tick of a known row, expect the typed values
        if (use_row && row.chk && bus_ph == PH_IDLE) begin
            r.presence  = row.pres;
            r.read_data = row.rd;
            r.crc       = row.crcv;
        end
        tick_q.push_back(r);
    endtask

    task automatic run_row(input cmd_row_t row);
        cmd_t c;
        res_t r;
        c.cmd_valid  = row.vld;
        c.func       = row.func;
        c.cmd_data   = row.data;
        c.line_level = line_of(row.line_mode);
        send_tick(c, 1'b1, row, r);
        while (bus_ph != PH_IDLE) begin
            c = rand_cmd($urandom_range(3) == 0);
            c.line_level = line_of(row.line_mode);
            send_tick(c, 1'b1, row, r);
        end
    endtask

    task automatic run_random(input int budget);
        cmd_t     c;
        res_t     r;
        cmd_row_t no_row;
        int       active;
        active = 0;
        while (active < budget || bus_ph != PH_IDLE) begin
            if (bus_ph == PH_IDLE) begin
                c = rand_cmd($urandom_range(9) < 7);
            end else begin
                c = rand_cmd($urandom_range(7) == 0);
            end
            send_tick(c, 1'b0, no_row, r);
            if (r.busy_res) begin
                active++;
            end
        end
    endtask

    // hold requests until every result is back and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tick_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] smp,
                             input logic [CFG_W-1:0] tail, input logic [CFG_W-1:0] slot);
        logic [CFG_W-1:0]     vals[4];
        logic [CFG_IDX_W-1:0] idx;
        vals = '{lo, smp, tail, slot};
        for (int i = 0; i < 4; i++) begin
            idx = CFG_IDX_W'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            @(posedge aclk);
            case (idx)
                CFG_RESET_LOW:     t_low  = vals[i];
                CFG_PRESENCE_SMP:  t_smp  = vals[i];
                CFG_PRESENCE_TAIL: t_tail = vals[i];
                default:           t_slot = vals[i];
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin snd_pct = 0;  rcv_pct = 0;  end
            1:       begin snd_pct = 51; rcv_pct = 0;  end
            2:       begin snd_pct = 0;  rcv_pct = 51; end
            default: begin snd_pct = 34; rcv_pct = 34; end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("mismatch: %s expected %02h got %02h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_pct);
    end

    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata);
            if (tick_q.size() == 0) begin
                report_mismatch("unexpected result", 8'h00, 8'h00);
            end else begin
                want = tick_q.pop_front();
                if (got.drive_low !== want.drive_low)
                    report_mismatch("drive_low", want.drive_low, got.drive_low);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", want.busy_res, got.busy_res);
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", want.done_res, got.done_res);
                if (got.presence !== want.presence)
                    report_mismatch("presence", want.presence, got.presence);
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, got.read_data);
                if (got.crc !== want.crc)
                    report_mismatch("crc", want.crc, got.crc);
                if (got.pad !== want.pad)
                    report_mismatch("pad", want.pad, got.pad);
            end
        end
    end

    // drop the run if neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        plan = '{
            '{1'b0, FUNC_RESET,  8'h00, LINE_RAND, 1'b1, 1'b0, 8'h00, 8'h00},
            '{1'b1, FUNC_UNUSED, 8'h5A, LINE_RAND, 1'b0, 1'b0, 8'h00, 8'h00},
            '{1'b1, FUNC_RESET,  8'h00, LINE_LOW,  1'b1, 1'b1, 8'h00, 8'h00},
            '{1'b1, FUNC_WRITE,  8'h00, LINE_RAND, 1'b0, 1'b0, 8'h00, 8'h00},
            '{1'b1, FUNC_WRITE,  8'hFF, LINE_RAND, 1'b0, 1'b0, 8'h00, 8'h00},
            '{1'b1, FUNC_WRITE,  8'hA5, LINE_RAND, 1'b0, 1'b0, 8'h00, 8'h00},
            '{1'b1, FUNC_READ,   8'hFF, LINE_LOW,  1'b1, 1'b1, 8'h00, 8'h00},
            '{1'b1, FUNC_READ,   8'h00, LINE_HIGH, 1'b0, 1'b0, 8'h00, 8'h00},
            '{1'b1, FUNC_RESET,  8'h00, LINE_HIGH, 1'b1, 1'b0, 8'hFF, 8'h00},
            '{1'b1, FUNC_READ,   8'h3C, LINE_RAND, 1'b0, 1'b0, 8'h00, 8'h00},
            '{1'b1, FUNC_RESET,  8'h00, LINE_RAND, 1'b0, 1'b0, 8'h00, 8'h00}
        };
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(0);
        // short timings keep the directed commands brief
        write_cfg(10'd6, 10'd3, 10'd4, 10'd5);
        foreach (plan[i]) begin
            run_row(plan[i]);
        end
        settle();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: write_cfg(10'd1, 10'd1, 10'd0, 10'd2);
                1: write_cfg(10'd0, 10'd0, 10'd3, 10'd0);
                2: write_cfg(10'd2, 10'd1, 10'd1, 10'd1);
                default: write_cfg(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 6)),
                                   CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(2, 8)));
            endcase
            set_idling(p % 4);
            run_random(RANDOM_TICKS / RANDOM_PHASES);
            settle();
        end
        if (errors == 0 && tick_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/owm_pkg.sv
design/owm_in_stage.sv
design/owm_ctrl.sv
design/owm_out_stage.sv
design/one_wire_bus_master_top.sv
dv/one_wire_bus_master_top_tb.sv
